// ----- rtl/vpet_pkg.sv -----
// ----------------------------------------------------------------------------
// Vehicle pass event tracker package
// Shared codes, widths and status types for the tracker and its submodules.
// ----------------------------------------------------------------------------
package vpet_pkg;

  localparam int DIST_W  = 16;
  localparam int SPEED_W = 16;
  localparam int TIME_W  = 32;
  localparam int ID_W    = 32;
  localparam int CNT_W   = 16;
  localparam int SUM_W   = 32;
  localparam int SCORE_W = 16;
  localparam int SDB_W   = 15;
  localparam int DDB_W   = 16;
  localparam int CFG_W   = 16;

  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [SPEED_W-1:0] MEAN_SAT  = 16'h8000;
  localparam logic [SDB_W-1:0]   SDB_RESET = 15'd50;
  localparam logic [DDB_W-1:0]   DDB_RESET = 16'd15;

  typedef enum logic [1:0] {
    REQ_MEASURE = 2'd0,
    REQ_FINISH  = 2'd1,
    REQ_CLEAR   = 2'd2
  } req_code_t;

  typedef enum logic [1:0] {
    DIR_UNKNOWN     = 2'd0,
    DIR_APPROACHING = 2'd1,
    DIR_RECEDING    = 2'd2
  } dir_code_t;

  typedef enum logic {
    CFG_SPEED_DB = 1'b0,
    CFG_DIST_DB  = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RESULT
  } vpet_state_t;

  typedef struct packed {
    logic             open;
    logic [ID_W-1:0]  cur_id;
    logic [TIME_W-1:0] start_time;
    logic [1:0]       direction;
    logic [CNT_W-1:0] count;
    logic [DIST_W-1:0] first_dist;
    logic [DIST_W-1:0] last_dist;
    logic [DIST_W-1:0] min_dist;
    logic [SPEED_W-1:0] max_speed;
    logic [SUM_W-1:0] speed_sum;
  } trk_view_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/vpet_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel that carries one radar request item.
// ----------------------------------------------------------------------------
interface vpet_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          req_type;
  logic [vpet_pkg::DIST_W-1:0]         distance_cm;
  logic signed [vpet_pkg::SPEED_W-1:0] speed_signed;
  logic [vpet_pkg::TIME_W-1:0]         time_ms;

  modport source (output valid, req_type, distance_cm, speed_signed, time_ms, input ready);
  modport sink (input valid, req_type, distance_cm, speed_signed, time_ms, output ready);
endinterface

// ----- rtl/vpet_evt_if.sv -----
// ----------------------------------------------------------------------------
// Event channel interface
// Valid/ready channel that carries one tracker result item.
// ----------------------------------------------------------------------------
interface vpet_evt_if;
  logic                          valid;
  logic                          ready;
  logic                          event_valid;
  logic [vpet_pkg::ID_W-1:0]     vehicle_id;
  logic [1:0]                    direction;
  logic [vpet_pkg::CNT_W-1:0]    sample_total;
  logic [vpet_pkg::DIST_W-1:0]   first_distance;
  logic [vpet_pkg::DIST_W-1:0]   last_distance;
  logic [vpet_pkg::DIST_W-1:0]   min_distance;
  logic [vpet_pkg::SPEED_W-1:0]  peak_speed;
  logic [vpet_pkg::SPEED_W-1:0]  mean_speed;
  logic [vpet_pkg::TIME_W-1:0]   pass_time_ms;

  modport source (output valid, event_valid, vehicle_id, direction, sample_total,
                  first_distance, last_distance, min_distance, peak_speed,
                  mean_speed, pass_time_ms, input ready);
  modport sink (input valid, event_valid, vehicle_id, direction, sample_total,
                first_distance, last_distance, min_distance, peak_speed,
                mean_speed, pass_time_ms, output ready);
endinterface

// ----- rtl/vpet_track.sv -----
// ----------------------------------------------------------------------------
// Track state
// Holds the open track and applies one request per update strobe.
// ----------------------------------------------------------------------------
module vpet_track (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                upd,
  input  logic [1:0]                          req_type,
  input  logic [vpet_pkg::DIST_W-1:0]         dist_cm,
  input  logic signed [vpet_pkg::SPEED_W-1:0] speed,
  input  logic [vpet_pkg::TIME_W-1:0]         time_ms,
  input  logic [vpet_pkg::SDB_W-1:0]          spd_db,
  input  logic [vpet_pkg::DDB_W-1:0]          dst_db,
  output vpet_pkg::trk_view_t                 view
);

  localparam int SW = vpet_pkg::SCORE_W;

  logic                          open_r, open_nxt;
  logic [vpet_pkg::ID_W-1:0]     idc_r, idc_nxt;
  logic [vpet_pkg::ID_W-1:0]     cur_id_r, cur_id_nxt;
  logic [vpet_pkg::TIME_W-1:0]   start_r, start_nxt;
  logic [vpet_pkg::DIST_W-1:0]   first_r, first_nxt;
  logic [vpet_pkg::DIST_W-1:0]   last_r, last_nxt;
  logic [vpet_pkg::DIST_W-1:0]   min_r, min_nxt;
  logic [vpet_pkg::DIST_W-1:0]   prev_r, prev_nxt;
  logic [vpet_pkg::SPEED_W-1:0]  maxs_r, maxs_nxt;
  logic [vpet_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [vpet_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic signed [SW-1:0]          score_r, score_nxt;

  logic [vpet_pkg::SPEED_W-1:0]  aspd;
  logic [vpet_pkg::DIST_W-1:0]   min_b, prev_b;
  logic [vpet_pkg::SPEED_W-1:0]  max_b;
  logic [vpet_pkg::SUM_W-1:0]    sum_b;
  logic [vpet_pkg::CNT_W-1:0]    cnt_b, cnt_m;
  logic signed [SW-1:0]          score_b, score_1;
  logic [vpet_pkg::SUM_W:0]      sum_wide;
  logic signed [vpet_pkg::SPEED_W:0] sp_x, sdb_x;
  logic signed [vpet_pkg::DIST_W:0]  delta, ddb_x;
  logic signed [2:0]             vote_s, vote_d;

  function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                                   input logic signed [2:0] b);
    logic signed [SW+1:0] s;
    s = {{2{a[SW-1]}}, a} + {{(SW-1){b[2]}}, b};
    if (s > $signed({3'b000, {(SW-1){1'b1}}})) begin
      sat_add = {1'b0, {(SW-1){1'b1}}};
    end else if (s < $signed({3'b111, {(SW-1){1'b0}}})) begin
      sat_add = {1'b1, {(SW-1){1'b0}}};
    end else begin
      sat_add = s[SW-1:0];
    end
  endfunction

  always_comb begin
    aspd  = speed[vpet_pkg::SPEED_W-1] ? (~speed + 1'b1) : speed;
    sp_x  = {speed[vpet_pkg::SPEED_W-1], speed};
    sdb_x = $signed({2'b00, spd_db});
    ddb_x = $signed({1'b0, dst_db});

    open_nxt   = open_r;
    idc_nxt    = idc_r;
    cur_id_nxt = cur_id_r;
    start_nxt  = start_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    min_nxt    = min_r;
    prev_nxt   = prev_r;
    maxs_nxt   = maxs_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    score_nxt  = score_r;

    min_b   = open_r ? min_r : dist_cm;
    prev_b  = open_r ? prev_r : dist_cm;
    max_b   = open_r ? maxs_r : aspd;
    sum_b   = open_r ? sum_r : '0;
    cnt_b   = open_r ? cnt_r : '0;
    score_b = open_r ? score_r : '0;

    cnt_m    = (cnt_b == {vpet_pkg::CNT_W{1'b1}}) ? cnt_b : cnt_b + 1'b1;
    sum_wide = {1'b0, sum_b} + {{(vpet_pkg::SUM_W-vpet_pkg::SPEED_W+1){1'b0}}, aspd};
    delta    = $signed({1'b0, dist_cm}) - $signed({1'b0, prev_b});

    if (sp_x < -sdb_x) begin
      vote_s = 3'sd2;
    end else if (sp_x > sdb_x) begin
      vote_s = -3'sd2;
    end else begin
      vote_s = 3'sd0;
    end

    if (cnt_m > {{(vpet_pkg::CNT_W-1){1'b0}}, 1'b1} && delta < -ddb_x) begin
      vote_d = 3'sd1;
    end else if (cnt_m > {{(vpet_pkg::CNT_W-1){1'b0}}, 1'b1} && delta > ddb_x) begin
      vote_d = -3'sd1;
    end else begin
      vote_d = 3'sd0;
    end

    score_1 = sat_add(score_b, vote_s);

    if (upd) begin
      case (req_type)
        vpet_pkg::REQ_MEASURE: begin
          if (!open_r) begin
            open_nxt   = 1'b1;
            cur_id_nxt = idc_r;
            idc_nxt    = idc_r + 1'b1;
            start_nxt  = time_ms;
            first_nxt  = dist_cm;
          end
          cnt_nxt   = cnt_m;
          last_nxt  = dist_cm;
          min_nxt   = (dist_cm < min_b) ? dist_cm : min_b;
          maxs_nxt  = (aspd > max_b) ? aspd : max_b;
          sum_nxt   = sum_wide[vpet_pkg::SUM_W] ? {vpet_pkg::SUM_W{1'b1}}
                                                : sum_wide[vpet_pkg::SUM_W-1:0];
          score_nxt = sat_add(score_1, vote_d);
          prev_nxt  = dist_cm;
        end
        vpet_pkg::REQ_FINISH: begin
          if (open_r && cnt_r != '0) begin
            open_nxt = 1'b0;
          end
        end
        vpet_pkg::REQ_CLEAR: begin
          open_nxt   = 1'b0;
          cur_id_nxt = '0;
          start_nxt  = '0;
          first_nxt  = '0;
          last_nxt   = '0;
          min_nxt    = '0;
          prev_nxt   = '0;
          maxs_nxt   = '0;
          sum_nxt    = '0;
          cnt_nxt    = '0;
          score_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      idc_r    <= '0;
      cur_id_r <= '0;
      start_r  <= '0;
      first_r  <= '0;
      last_r   <= '0;
      min_r    <= '0;
      prev_r   <= '0;
      maxs_r   <= '0;
      sum_r    <= '0;
      cnt_r    <= '0;
      score_r  <= '0;
    end else begin
      open_r   <= open_nxt;
      idc_r    <= idc_nxt;
      cur_id_r <= cur_id_nxt;
      start_r  <= start_nxt;
      first_r  <= first_nxt;
      last_r   <= last_nxt;
      min_r    <= min_nxt;
      prev_r   <= prev_nxt;
      maxs_r   <= maxs_nxt;
      sum_r    <= sum_nxt;
      cnt_r    <= cnt_nxt;
      score_r  <= score_nxt;
    end
  end

  always_comb begin
    view.open       = open_r;
    view.cur_id     = cur_id_r;
    view.start_time = start_r;
    view.count      = cnt_r;
    view.first_dist = first_r;
    view.last_dist  = last_r;
    view.min_dist   = min_r;
    view.max_speed  = maxs_r;
    view.speed_sum  = sum_r;
    if (score_r > 0) begin
      view.direction = vpet_pkg::DIR_APPROACHING;
    end else if (score_r < 0) begin
      view.direction = vpet_pkg::DIR_RECEDING;
    end else begin
      view.direction = vpet_pkg::DIR_UNKNOWN;
    end
  end

endmodule

// ----- rtl/vpet_div.sv -----
// ----------------------------------------------------------------------------
// Serial mean speed divider
// Restoring division of the speed sum by the sample count, one quotient bit
// per cycle, with the quotient saturated to the mean speed range.
// ----------------------------------------------------------------------------
module vpet_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [vpet_pkg::SUM_W-1:0]    dividend,
  input  logic [vpet_pkg::CNT_W-1:0]    divisor,
  output vpet_pkg::div_stat_t           stat,
  output logic [vpet_pkg::SPEED_W-1:0]  quotient
);

  localparam int DW = vpet_pkg::CNT_W;
  localparam int QW = vpet_pkg::SUM_W;

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [vpet_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]                  rem_r, rem_nxt;
  logic [QW-1:0]                  quo_r, quo_nxt;
  logic [DW-1:0]                  dvs_r, dvs_nxt;
  logic [DW:0]                    shf;
  logic [DW+1:0]                  diff;
  logic                           ge;

  always_comb begin
    shf  = {rem_r, quo_r[QW-1]};
    diff = {1'b0, shf} - {2'b00, dvs_r};
    ge   = ~diff[DW+1];

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : shf[DW-1:0];
      quo_nxt = {quo_r[QW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == vpet_pkg::DIV_CNT_W'(vpet_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = (quo_r > QW'(vpet_pkg::MEAN_SAT)) ? vpet_pkg::MEAN_SAT
                                                        : quo_r[vpet_pkg::SPEED_W-1:0];

endmodule

// ----- rtl/vehicle_pass_event_tracker.sv -----
// ----------------------------------------------------------------------------
// Vehicle pass event tracker
// Collects radar speed and distance samples into vehicle pass events.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch and each one produces exactly one result on out_ch;
// both channels transfer when valid and ready are high at a rising clock edge.
// The result of a measurement, a clear or an unused request code passes from
// the RESULT state into the output register, and the next request can transfer
// once the block is back in IDLE. A finish that closes a track first runs the
// serial divider for the mean speed in the DIV state, one quotient bit per cycle
// over the 32 bits of the speed sum, and then takes the same path to its result.
// One request is processed at a time; in_ch.ready is high only while idle.
// The result sits in an output register, so a new request can be taken while
// the previous result still waits; when out_ch.ready stays low the block
// holds its next result and stops taking requests.
// The dead band registers are written on cfg_we with cfg_idx selecting the
// register; write them only while the block is idle.
// Synchronous reset clears the open track, the id counter and the output
// valid, and restores the dead bands to 50 and 15.
// ----------------------------------------------------------------------------
module vehicle_pass_event_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  vpet_req_if.sink                      in_ch,
  vpet_evt_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic                          cfg_idx,
  input  logic [vpet_pkg::CFG_W-1:0]    cfg_wdata
);

  vpet_pkg::vpet_state_t        state_r, state_nxt;
  vpet_pkg::trk_view_t          view;
  vpet_pkg::div_stat_t          dstat;
  logic [vpet_pkg::SPEED_W-1:0] div_q;
  logic [vpet_pkg::SDB_W-1:0]   sdb_r;
  logic [vpet_pkg::DDB_W-1:0]   ddb_r;
  logic                         acc, fin_ev, div_start, res_ld, in_ready;
  logic                         evt_r;
  logic [vpet_pkg::TIME_W-1:0]  dur_r;
  logic                         out_valid_r;

  assign acc    = in_ch.valid && in_ready;
  assign fin_ev = (in_ch.req_type == vpet_pkg::REQ_FINISH) && view.open &&
                  (view.count != '0);
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sdb_r <= vpet_pkg::SDB_RESET;
      ddb_r <= vpet_pkg::DDB_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        vpet_pkg::CFG_SPEED_DB: sdb_r <= cfg_wdata[vpet_pkg::SDB_W-1:0];
        vpet_pkg::CFG_DIST_DB:  ddb_r <= cfg_wdata[vpet_pkg::DDB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  vpet_track u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (acc),
    .req_type (in_ch.req_type),
    .dist_cm  (in_ch.distance_cm),
    .speed    (in_ch.speed_signed),
    .time_ms  (in_ch.time_ms),
    .spd_db   (sdb_r),
    .dst_db   (ddb_r),
    .view     (view)
  );

  vpet_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (view.speed_sum),
    .divisor  (view.count),
    .stat     (dstat),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    res_ld    = 1'b0;
    case (state_r)
      vpet_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          if (fin_ev) begin
            div_start = 1'b1;
            state_nxt = vpet_pkg::ST_DIV;
          end else begin
            state_nxt = vpet_pkg::ST_RESULT;
          end
        end
      end
      vpet_pkg::ST_DIV: begin
        if (dstat.done) begin
          state_nxt = vpet_pkg::ST_RESULT;
        end
      end
      vpet_pkg::ST_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          res_ld    = 1'b1;
          state_nxt = vpet_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vpet_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vpet_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      evt_r <= fin_ev;
      dur_r <= in_ch.time_ms - view.start_time;
    end
    if (res_ld) begin
      out_ch.event_valid    <= evt_r;
      out_ch.vehicle_id     <= view.cur_id;
      out_ch.direction      <= view.direction;
      out_ch.sample_total   <= view.count;
      out_ch.first_distance <= view.first_dist;
      out_ch.last_distance  <= view.last_dist;
      out_ch.min_distance   <= view.min_dist;
      out_ch.peak_speed     <= view.max_speed;
      out_ch.mean_speed     <= evt_r ? div_q : '0;
      out_ch.pass_time_ms   <= evt_r ? dur_r : '0;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

// ----- rtl/vpet_checker.sv -----
// ----------------------------------------------------------------------------
// Tracker port checker
// Watches the tracker's channels for result consistency and handshake rules.
// ----------------------------------------------------------------------------
module vpet_checker (
  input logic        clk,
  input logic        rst_n,
  vpet_req_if.sink   in_ch,
  vpet_evt_if.source out_ch
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("Result valid dropped before its transfer.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("A request was taken while another was in progress.");

  a_event_has_samples: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.event_valid |-> out_ch.sample_total != 16'd0)
    else $error("An event was reported for an empty track.");

  a_no_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.event_valid |->
      out_ch.mean_speed == 16'd0 && out_ch.pass_time_ms == 32'd0)
    else $error("Mean speed or pass time is set without an event.");

  a_min_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.min_distance <= out_ch.last_distance &&
                     out_ch.min_distance <= out_ch.first_distance)
    else $error("Minimum distance exceeds the first or last distance.");

endmodule

bind vehicle_pass_event_tracker vpet_checker u_vpet_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vehicle pass event tracker testbench
// Drives radar requests into the tracker and predicts every result in step
// with each accepted transfer. The stimulus starts with a directed set of
// corner items, then a steady track at the speed extremes, then random pass
// tracks under several dead band settings. Both channels idle at random, and
// the receiver holds off once long enough to back up the block.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int LONG_APPROACH = 35;
  localparam int LONG_TRACK = 60;
  localparam int PHASE_ITEMS = 185;

  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] dist_cm;
    logic [15:0] speed;
    logic [31:0] tms;
  } radar_req_t;

  typedef struct packed {
    logic        ev_valid;
    logic [31:0] id;
    logic [1:0]  dir;
    logic [15:0] total;
    logic [15:0] first_d;
    logic [15:0] last_d;
    logic [15:0] min_d;
    logic [15:0] peak;
    logic [15:0] mean;
    logic [31:0] dur;
  } pass_evt_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_idx;
  logic [vpet_pkg::CFG_W-1:0] cfg_wdata;

  vpet_req_if req_ch ();
  vpet_evt_if evt_ch ();

  vehicle_pass_event_tracker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (evt_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  radar_req_t radar_backlog[$];
  pass_evt_t  pending_events[$];
  radar_req_t in_flight;

  logic [vpet_pkg::SDB_W-1:0] speed_band = vpet_pkg::SDB_RESET;
  logic [vpet_pkg::DDB_W-1:0] dist_band = vpet_pkg::DDB_RESET;

  logic        trk_open = 1'b0;
  logic [31:0] next_id = '0;
  logic [31:0] cur_id = '0;
  logic [31:0] t_start = '0;
  logic [15:0] d_first = '0;
  logic [15:0] d_last = '0;
  logic [15:0] d_min = '0;
  logic [15:0] d_prev = '0;
  logic [15:0] v_peak = '0;
  logic [31:0] v_sum = '0;
  logic [15:0] n_samples = '0;
  int          dir_score = 0;

  int  errors = 0;
  int  requests_taken = 0;
  int  results_checked = 0;
  int  events_closed = 0;
  int  hold_left = 0;
  bit  steady = 1'b0;

  function automatic void bump_score(input int delta);
    dir_score = dir_score + delta;
    if (dir_score > 32767) dir_score = 32767;
    if (dir_score < -32768) dir_score = -32768;
  endfunction

  function automatic pass_evt_t advance_tracker(input radar_req_t rq);
    pass_evt_t ev;
    int spd;
    int aspd;
    int delta;
    logic [31:0] quo;
    ev = '0;
    spd = $signed(rq.speed);
    aspd = (spd < 0) ? -spd : spd;
    case (rq.req)
      vpet_pkg::REQ_MEASURE: begin
        if (!trk_open) begin
          trk_open = 1'b1;
          cur_id = next_id;
          next_id = next_id + 32'd1;
          t_start = rq.tms;
          d_first = rq.dist_cm;
          d_min = rq.dist_cm;
          v_peak = 16'(aspd);
          v_sum = '0;
          n_samples = '0;
          dir_score = 0;
        end
        if (n_samples != 16'hFFFF) n_samples = n_samples + 16'd1;
        d_last = rq.dist_cm;
        if (rq.dist_cm < d_min) d_min = rq.dist_cm;
        if (aspd > int'(v_peak)) v_peak = 16'(aspd);
        if (longint'(v_sum) + aspd > 64'd4294967295) v_sum = '1;
        else v_sum = v_sum + 32'(aspd);
        if (spd < -int'(speed_band)) bump_score(2);
        if (spd > int'(speed_band)) bump_score(-2);
        if (n_samples > 16'd1) begin
          delta = int'(rq.dist_cm) - int'(d_prev);
          if (delta < -int'(dist_band)) bump_score(1);
          if (delta > int'(dist_band)) bump_score(-1);
        end
        d_prev = rq.dist_cm;
      end
      vpet_pkg::REQ_FINISH: begin
        if (trk_open && n_samples != 0) begin
          quo = v_sum / n_samples;
          ev.mean = (quo > 32'd32768) ? vpet_pkg::MEAN_SAT : quo[15:0];
          ev.dur = rq.tms - t_start;
          ev.ev_valid = 1'b1;
          trk_open = 1'b0;
        end
      end
      vpet_pkg::REQ_CLEAR: begin
        trk_open = 1'b0;
        cur_id = '0;
        t_start = '0;
        d_first = '0;
        d_last = '0;
        d_min = '0;
        d_prev = '0;
        v_peak = '0;
        v_sum = '0;
        n_samples = '0;
        dir_score = 0;
      end
      default: ;
    endcase
    ev.id = cur_id;
    ev.dir = (dir_score > 0) ? vpet_pkg::DIR_APPROACHING :
             (dir_score < 0) ? vpet_pkg::DIR_RECEDING : vpet_pkg::DIR_UNKNOWN;
    ev.total = n_samples;
    ev.first_d = d_first;
    ev.last_d = d_last;
    ev.min_d = d_min;
    ev.peak = v_peak;
    return ev;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t tb_top: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endfunction

  function automatic void compare_event();
    pass_evt_t want;
    if (pending_events.size() == 0) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t tb_top: result transfer with nothing expected, expected none, actual id %0h",
                 $time, evt_ch.vehicle_id);
      end
    end else begin
      want = pending_events.pop_front();
      check_field("event_valid", 64'(want.ev_valid), 64'(evt_ch.event_valid));
      check_field("vehicle_id", 64'(want.id), 64'(evt_ch.vehicle_id));
      check_field("direction", 64'(want.dir), 64'(evt_ch.direction));
      check_field("sample_total", 64'(want.total), 64'(evt_ch.sample_total));
      check_field("first_distance", 64'(want.first_d), 64'(evt_ch.first_distance));
      check_field("last_distance", 64'(want.last_d), 64'(evt_ch.last_distance));
      check_field("min_distance", 64'(want.min_d), 64'(evt_ch.min_distance));
      check_field("peak_speed", 64'(want.peak), 64'(evt_ch.peak_speed));
      check_field("mean_speed", 64'(want.mean), 64'(evt_ch.mean_speed));
      check_field("pass_time_ms", 64'(want.dur), 64'(evt_ch.pass_time_ms));
      if (want.ev_valid) events_closed++;
    end
    results_checked++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        pending_events.push_back(advance_tracker(in_flight));
        requests_taken++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (radar_backlog.size() > 0 && (steady || $urandom_range(99) >= 23)) begin
          in_flight = radar_backlog.pop_front();
          req_ch.req_type <= in_flight.req;
          req_ch.distance_cm <= in_flight.dist_cm;
          req_ch.speed_signed <= in_flight.speed;
          req_ch.time_ms <= in_flight.tms;
          req_ch.valid <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      evt_ch.ready <= 1'b0;
    end else begin
      if (evt_ch.valid && evt_ch.ready) compare_event();
      if (hold_left > 0) begin
        hold_left--;
        evt_ch.ready <= 1'b0;
      end else begin
        evt_ch.ready <= steady || ($urandom_range(99) >= 23);
      end
    end
  end

  task automatic queue_req(input logic [1:0] code, input logic [15:0] d,
                           input logic [15:0] s, input logic [31:0] t);
    radar_backlog.push_back(radar_req_t'{req: code, dist_cm: d, speed: s, tms: t});
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (radar_backlog.size() != 0 || req_ch.valid || pending_events.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_band(input vpet_pkg::cfg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    if (idx == vpet_pkg::CFG_SPEED_DB) speed_band = val[14:0];
    else dist_band = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One pass: a run of measurements drifting toward or away from the radar,
  // with part of the speeds near the dead band edge, then usually a finish.
  task automatic queue_pass(output int n_items);
    int n;
    int d;
    int step;
    int mag;
    int spd;
    bit toward;
    logic [31:0] t;
    n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    toward = 1'($urandom_range(1));
    d = $urandom_range(65535);
    t = $urandom;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(2) == 0 && dist_band < 16'd65000) begin
        step = int'(dist_band) + $urandom_range(2) - 1;
      end else begin
        step = $urandom_range(60);
      end
      if (step < 0) step = 0;
      if ($urandom_range(4) == 0) step = -step;
      d = toward ? d - step : d + step;
      if (d < 0) d = 0;
      if (d > 65535) d = 65535;
      case ($urandom_range(9))
        0: mag = $urandom_range(32768);
        1, 2, 3: mag = int'(speed_band) + $urandom_range(2) - 1;
        default: mag = $urandom_range(3000);
      endcase
      if (mag < 0) mag = 0;
      spd = (toward ^ ($urandom_range(6) == 0)) ? -mag : mag;
      if (spd > 32767) spd = 32767;
      queue_req(vpet_pkg::REQ_MEASURE, d[15:0], spd[15:0], t);
      t = t + $urandom_range(20, 200);
    end
    case ($urandom_range(9))
      0: queue_req(vpet_pkg::REQ_CLEAR, 16'($urandom), 16'($urandom), $urandom);
      1: ;
      default: queue_req(vpet_pkg::REQ_FINISH, 16'($urandom), 16'($urandom),
                         t + $urandom_range(500));
    endcase
    n_items = n + 1;
  endtask

  task automatic random_phase(input int quota);
    int queued;
    int n;
    queued = 0;
    while (queued < quota) begin
      if ($urandom_range(5) == 0) begin
        queue_req(2'($urandom_range(3)), 16'($urandom), 16'($urandom), $urandom);
      end else begin
        queue_pass(n);
        queued += n;
      end
    end
  endtask

  initial begin
    logic [31:0] t;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = '0;
    req_ch.distance_cm = '0;
    req_ch.speed_signed = '0;
    req_ch.time_ms = '0;
    evt_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Requests with no track, band edges, field extremes and time wrap.
    queue_req(vpet_pkg::REQ_FINISH, 16'd0, 16'h0000, 32'd100);
    queue_req(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_req(vpet_pkg::REQ_CLEAR, 16'd0, 16'h0000, 32'd0);
    queue_req(vpet_pkg::REQ_MEASURE, 16'd1000, 16'h8000, 32'hFFFF_FFF0);
    queue_req(vpet_pkg::REQ_MEASURE, 16'd1015, -16'sd50, 32'hFFFF_FFF4);
    queue_req(vpet_pkg::REQ_MEASURE, 16'd1031, -16'sd51, 32'hFFFF_FFF8);
    queue_req(vpet_pkg::REQ_MEASURE, 16'd1016, 16'sd50, 32'hFFFF_FFFA);
    queue_req(vpet_pkg::REQ_MEASURE, 16'd1000, 16'sd51, 32'hFFFF_FFFC);
    queue_req(vpet_pkg::REQ_MEASURE, 16'd0, 16'h7FFF, 32'hFFFF_FFFE);
    queue_req(vpet_pkg::REQ_MEASURE, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
    queue_req(REQ_UNUSED, 16'd0, 16'h0000, 32'd0);
    queue_req(vpet_pkg::REQ_FINISH, 16'd0, 16'h0000, 32'h0000_0010);
    queue_req(vpet_pkg::REQ_FINISH, 16'd0, 16'h0000, 32'h0000_0020);
    queue_req(vpet_pkg::REQ_MEASURE, 16'd500, -16'sd300, 32'd1000);
    queue_req(vpet_pkg::REQ_CLEAR, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_req(vpet_pkg::REQ_FINISH, 16'd0, 16'h0000, 32'd2000);
    queue_req(vpet_pkg::REQ_MEASURE, 16'hFFFF, 16'h7FFF, 32'd0);
    queue_req(vpet_pkg::REQ_FINISH, 16'd0, 16'h0000, 32'hFFFF_FFFF);
    queue_req(vpet_pkg::REQ_MEASURE, 16'd0, -16'sd1, 32'd7);
    queue_req(vpet_pkg::REQ_MEASURE, 16'd0, 16'sd1, 32'd7);
    queue_req(vpet_pkg::REQ_FINISH, 16'd0, 16'h0000, 32'd7);
    queue_req(vpet_pkg::REQ_MEASURE, 16'hFFFF, 16'h8000, 32'h8000_0000);
    queue_req(vpet_pkg::REQ_CLEAR, 16'd0, 16'h0000, 32'd0);
    wait_quiet();

    // A steady track at the speed extremes in both directions, sent without
    // idling on either side.
    steady = 1'b1;
    t = 32'hFFFF_FFE0;
    for (int i = 0; i < LONG_TRACK; i++) begin
      queue_req(vpet_pkg::REQ_MEASURE, 16'($urandom),
                (i < LONG_APPROACH) ? 16'h8000 : 16'h7FFF, t);
      t = t + 32'd1;
    end
    queue_req(vpet_pkg::REQ_FINISH, 16'd0, 16'h0000, t);
    wait_quiet();
    steady = 1'b0;

    write_band(vpet_pkg::CFG_SPEED_DB, 16'd0);
    write_band(vpet_pkg::CFG_DIST_DB, 16'd0);
    random_phase(PHASE_ITEMS);
    hold_left = 400;
    wait_quiet();

    write_band(vpet_pkg::CFG_SPEED_DB, 16'hFFFF);
    write_band(vpet_pkg::CFG_DIST_DB, 16'hFFFF);
    random_phase(PHASE_ITEMS);
    wait_quiet();

    write_band(vpet_pkg::CFG_SPEED_DB, 16'($urandom_range(300)));
    write_band(vpet_pkg::CFG_DIST_DB, 16'($urandom_range(100)));
    random_phase(PHASE_ITEMS);
    wait_quiet();

    write_band(vpet_pkg::CFG_SPEED_DB, 16'(vpet_pkg::SDB_RESET));
    write_band(vpet_pkg::CFG_DIST_DB, vpet_pkg::DDB_RESET);
    random_phase(PHASE_ITEMS);
    wait_quiet();

    $display("tb_top: %0d request transfers, %0d result transfers checked, %0d closed passes",
             requests_taken, results_checked, events_closed);
    $display("tb_top: five dead band settings incl. both extremes, one %0d sample track",
             LONG_TRACK);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ----- vehicle_pass_event_tracker.f -----
rtl/vpet_pkg.sv
rtl/vpet_req_if.sv
rtl/vpet_evt_if.sv
rtl/vpet_track.sv
rtl/vpet_div.sv
rtl/vehicle_pass_event_tracker.sv
rtl/vpet_checker.sv
bench/tb_top.sv
